// ----- sv/assert_macros.svh -----
// assertion helpers, sampled on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ehv_pkg.sv -----
`default_nettype none
package ehv_pkg;

  localparam int MaxFrameBytesDefault = 2048;
  localparam int QueueDepthDefault    = 2;

  localparam logic [11:0] EthLen  = 12'd14;
  localparam logic [11:0] ArpEnd  = 12'd42;
  localparam logic [15:0] EtypeIp  = 16'h0800;
  localparam logic [15:0] EtypeArp = 16'h0806;
  localparam logic [7:0]  ProtoIcmp = 8'd1;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;

  typedef enum logic [3:0] {
    OC_SHORT_ETH = 4'd0,
    OC_UNKNOWN   = 4'd1,
    OC_IP_SHORT  = 4'd2,
    OC_ARP_SHORT = 4'd3,
    OC_ARP_FMT   = 4'd4,
    OC_ARP_OK    = 4'd5,
    OC_IHL_OVER  = 4'd6,
    OC_LEN_OVER  = 4'd7,
    OC_FRAGMENT  = 4'd8,
    OC_PROTO     = 4'd9,
    OC_L4_SHORT  = 4'd10,
    OC_OK        = 4'd11
  } outcome_t;

  typedef enum logic [1:0] {
    KIND_ICMP = 2'd0,
    KIND_TCP  = 2'd1,
    KIND_UDP  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [11:0] end_offset;
    kind_t       transport_kind;
    logic [11:0] transport_offset;
    logic [11:0] payload_offset;
    logic        payload_valid;
    logic        length_saturated;
  } out_item_t;

  // header fields captured for one frame, handed from front to back
  typedef struct packed {
    logic [11:0] len;
    logic [15:0] ether_type;
    logic        arp_ok;
    logic [3:0]  hdr_words;
    logic [15:0] ip_len;
    logic        frag_nz;
    logic [7:0]  proto;
    logic [3:0]  tcp_words;
    logic [15:0] udp_len;
    logic [7:0]  icmp_type;
    logic        ovf;
  } snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- sv/ehv_front.sv -----
`default_nettype none
module ehv_front import ehv_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MaxFrameBytesDefault
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_stall,
  input  wire in_item_t in_data,
  output logic          push,
  output snap_t         snap
);

  localparam logic [11:0] MaxBytes = 12'(MAX_FRAME_BYTES);

  logic [11:0] cnt_r, cnt_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic        arp_ok_r, arp_ok_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [15:0] iplen_r, iplen_nxt;
  logic [15:0] frag_r, frag_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [3:0]  tcpw_r, tcpw_nxt;
  logic [15:0] udpl_r, udpl_nxt;
  logic [7:0]  ityp_r, ityp_nxt;
  logic        ovf_r, ovf_nxt;
  logic        acc, inrange;
  logic [7:0]  b;
  logic [11:0] tp;

  assign acc     = in_valid && !in_stall;
  assign b       = in_data.frame_byte;
  assign inrange = cnt_r < MaxBytes;
  assign push    = acc && in_data.last_byte;

  always_comb begin
    cnt_nxt    = cnt_r;
    etype_nxt  = etype_r;
    arp_ok_nxt = arp_ok_r;
    hw_nxt     = hw_r;
    iplen_nxt  = iplen_r;
    frag_nxt   = frag_r;
    proto_nxt  = proto_r;
    tcpw_nxt   = tcpw_r;
    udpl_nxt   = udpl_r;
    ityp_nxt   = ityp_r;
    ovf_nxt    = ovf_r;
    tp         = '0;
    if (inrange) begin
      case (cnt_r)
        12'd12: etype_nxt[15:8] = b;
        12'd13: etype_nxt[7:0]  = b;
        12'd14: begin
          hw_nxt = b[3:0];
          if (b != 8'h00) arp_ok_nxt = 1'b0;
        end
        12'd15: if (b != 8'h01) arp_ok_nxt = 1'b0;
        12'd16: begin
          iplen_nxt[15:8] = b;
          if (b != 8'h08) arp_ok_nxt = 1'b0;
        end
        12'd17: begin
          iplen_nxt[7:0] = b;
          if (b != 8'h00) arp_ok_nxt = 1'b0;
        end
        12'd18: if (b != 8'd6) arp_ok_nxt = 1'b0;
        12'd19: if (b != 8'd4) arp_ok_nxt = 1'b0;
        12'd20: frag_nxt[15:8] = b;
        12'd21: frag_nxt[7:0]  = b;
        12'd23: proto_nxt = b;
        default: ;
      endcase
      // transport header position follows the (possibly just captured) ihl
      tp = EthLen + {6'd0, hw_nxt, 2'b00};
      if (cnt_r == tp)          ityp_nxt = b;
      if (cnt_r == tp + 12'd4)  udpl_nxt[15:8] = b;
      if (cnt_r == tp + 12'd5)  udpl_nxt[7:0]  = b;
      if (cnt_r == tp + 12'd12) tcpw_nxt = b[7:4];
      cnt_nxt = cnt_r + 12'd1;
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  always_comb begin
    snap.len        = cnt_nxt;
    snap.ether_type = etype_nxt;
    snap.arp_ok     = arp_ok_nxt;
    snap.hdr_words  = hw_nxt;
    snap.ip_len     = iplen_nxt;
    snap.frag_nz    = frag_nxt[13:0] != 14'd0;
    snap.proto      = proto_nxt;
    snap.tcp_words  = tcpw_nxt;
    snap.udp_len    = udpl_nxt;
    snap.icmp_type  = ityp_nxt;
    snap.ovf        = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      cnt_r    <= '0;
      etype_r  <= '0;
      arp_ok_r <= 1'b1;
      hw_r     <= '0;
      iplen_r  <= '0;
      frag_r   <= '0;
      proto_r  <= '0;
      tcpw_r   <= '0;
      udpl_r   <= '0;
      ityp_r   <= '0;
      ovf_r    <= 1'b0;
    end else if (acc) begin
      cnt_r    <= cnt_nxt;
      etype_r  <= etype_nxt;
      arp_ok_r <= arp_ok_nxt;
      hw_r     <= hw_nxt;
      iplen_r  <= iplen_nxt;
      frag_r   <= frag_nxt;
      proto_r  <= proto_nxt;
      tcpw_r   <= tcpw_nxt;
      udpl_r   <= udpl_nxt;
      ityp_r   <= ityp_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ehv_queue.sv -----
`default_nettype none
module ehv_queue import ehv_pkg::*; #(
  parameter int DEPTH = QueueDepthDefault
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire snap_t wr_data,
  input  wire logic  pop,
  output snap_t      rd_data,
  output q_stat_t    stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(DEPTH);

  snap_t           mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign stat.full  = cnt_r == Full;
  assign stat.empty = cnt_r == '0;
  assign rd_data    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == LastPtr) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == LastPtr) ? '0 : rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

// ----- sv/ehv_back.sv -----
`default_nettype none
module ehv_back import ehv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire snap_t head,
  input  wire logic  head_valid,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_data
);

  out_item_t res_r, res_nxt;
  logic      vld_r;

  // icmp message sizes; known types only
  function automatic logic [4:0] icmp_size(input logic [7:0] t);
    case (t)
      8'd0, 8'd3, 8'd4, 8'd5, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12,
      8'd15, 8'd16, 8'd37:                 icmp_size = 5'd4;
      8'd17, 8'd18, 8'd38:                 icmp_size = 5'd8;
      8'd13, 8'd14:                        icmp_size = 5'd16;
      default:                             icmp_size = 5'd0;
    endcase
  endfunction

  function automatic logic icmp_known(input logic [7:0] t);
    case (t)
      8'd0, 8'd3, 8'd4, 8'd5, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13,
      8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd37, 8'd38: icmp_known = 1'b1;
      default:                                         icmp_known = 1'b0;
    endcase
  endfunction

  always_comb begin
    logic [11:0] len, eth_hl;
    logic [16:0] ip_end, end17, tp17, q17, th17;
    outcome_t    oc;
    kind_t       kind;
    logic [11:0] endo, toff, poff;
    logic        pv;

    len    = head.len;
    eth_hl = EthLen + {6'd0, head.hdr_words, 2'b00};
    ip_end = 17'(EthLen) + {1'b0, head.ip_len};
    tp17   = {5'd0, eth_hl};
    oc     = OC_OK;
    kind   = KIND_NONE;
    endo   = len;
    toff   = '0;
    poff   = '0;
    pv     = 1'b0;
    th17   = '0;
    end17  = '0;
    q17    = '0;
    if (len < EthLen) begin
      oc = OC_SHORT_ETH;
    end else if (head.ether_type == EtypeArp) begin
      if (len < EthLen + 12'd8) oc = OC_ARP_SHORT;
      else if (!head.arp_ok) oc = OC_ARP_FMT;
      else begin
        oc   = OC_ARP_OK;
        poff = EthLen + 12'd8;
        pv   = len >= ArpEnd;
        if (len > ArpEnd) endo = ArpEnd;
      end
    end else if (head.ether_type != EtypeIp) begin
      oc = OC_UNKNOWN;
    end else if (len < EthLen + 12'd20) begin
      oc = OC_IP_SHORT;
    end else if (eth_hl > len) begin
      oc = OC_IHL_OVER;
    end else if (ip_end > {5'd0, len}) begin
      oc = OC_LEN_OVER;
    end else if (head.frag_nz) begin
      oc = OC_FRAGMENT;
    end else begin
      endo  = ip_end[11:0];
      end17 = ip_end;
      if (head.proto == ProtoIcmp) begin
        kind = KIND_ICMP;
        th17 = 17'd4;
      end else if (head.proto == ProtoTcp) begin
        kind = KIND_TCP;
        if (tp17 + 17'd20 > end17) oc = OC_L4_SHORT;
        else th17 = {11'd0, head.tcp_words, 2'b00};
      end else if (head.proto == ProtoUdp) begin
        kind = KIND_UDP;
        th17 = 17'd8;
      end else begin
        oc = OC_PROTO;
      end
      q17 = tp17 + th17;
      if (oc == OC_OK && q17 > end17) oc = OC_L4_SHORT;
      if (oc == OC_OK) begin
        toff = eth_hl;
        poff = q17[11:0];
        case (kind)
          KIND_ICMP: pv = icmp_known(head.icmp_type) &&
                          (q17 + {12'd0, icmp_size(head.icmp_type)} <= end17);
          KIND_TCP:  pv = q17 < end17;
          default:   pv = tp17 + {1'b0, head.udp_len} <= end17;
        endcase
      end
    end
    res_nxt.outcome          = oc;
    res_nxt.end_offset       = endo;
    res_nxt.transport_kind   = kind;
    res_nxt.transport_offset = toff;
    res_nxt.payload_offset   = poff;
    res_nxt.payload_valid    = pv;
    res_nxt.length_saturated = head.ovf;
  end

  assign pop       = head_valid && (!vld_r || !out_stall);
  assign out_valid = vld_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (pop) begin
      vld_r <= 1'b1;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= res_nxt;
  end

endmodule
`default_nettype wire

// ----- sv/ethernet_ip_header_validator_unit.sv -----
`default_nettype none
// Ethernet / IPv4 header validator. Frame bytes enter one per clock on the in_
// channel while in_stall is low, last_byte marking the end of a frame; the block
// never throttles a running frame unless QUEUE_DEPTH verdicts are already waiting
// behind a stalled out_ channel. Header fields are captured at their fixed offsets
// as bytes pass (ethertype, ARP format words, IHL, total length, fragment word,
// protocol, TCP data offset, UDP length, ICMP type), only the first MAX_FRAME_BYTES
// bytes count, and later bytes set length_saturated. One verdict item leaves per
// frame, passing through a queue entry and the output register after the last byte
// is accepted. Sustained rate is one byte per clock while in_stall is low, and a new
// frame may start on the very next clock after a last byte; the queue depth sets
// how many verdicts can pile up behind a stalled output before in_stall rises.
module ethernet_ip_header_validator_unit import ehv_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MaxFrameBytesDefault,
  parameter int QUEUE_DEPTH     = QueueDepthDefault
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

`include "assert_macros.svh"

  snap_t   fr_snap, q_head;
  logic    push, pop;
  q_stat_t q_stat;

  // front stalls only when the verdict queue has no room
  assign in_stall = q_stat.full;

  // front: byte counting and header field capture
  ehv_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .snap     (fr_snap)
  );

  // short queue of captured frames waiting for a verdict
  ehv_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (fr_snap),
    .pop     (pop),
    .rd_data (q_head),
    .stat    (q_stat)
  );

  // back: verdict and output register
  ehv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_stat.empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // a frame end always leaves something in the queue next cycle
  `ASSERT_NEXT(a_push_lands, in_valid && !in_stall && in_data.last_byte, !q_stat.empty, "frame end lost")
  // a verdict only appears when the queue had one
  `ASSERT_IMPLY(a_out_src, $rose(out_valid), $past(!q_stat.empty), "verdict without frame")
  // arp ok always points payload right after the arp header
  `ASSERT_IMPLY(a_arp_poff, out_valid && out_data.outcome == OC_ARP_OK, out_data.payload_offset == 12'd22 && out_data.end_offset <= 12'd42, "arp offsets")

endmodule
`default_nettype wire

// ----- verif/ehv_checker.sv -----
package ehv_tb_pkg;

  localparam logic [15:0] EtypeIpv6   = 16'h86DD;
  localparam logic [15:0] ArpHwEther  = 16'h0001;
  localparam logic [7:0]  ArpHwLen    = 8'd6;
  localparam logic [7:0]  ArpProtoLen = 8'd4;
  localparam logic [7:0]  ProtoIgmp   = 8'd2;

  localparam logic [7:0] IcmpEchoReply   = 8'd0;
  localparam logic [7:0] IcmpUnreach     = 8'd3;
  localparam logic [7:0] IcmpSrcQuench   = 8'd4;
  localparam logic [7:0] IcmpRedirect    = 8'd5;
  localparam logic [7:0] IcmpEcho        = 8'd8;
  localparam logic [7:0] IcmpRtrAdvert   = 8'd9;
  localparam logic [7:0] IcmpRtrSolicit  = 8'd10;
  localparam logic [7:0] IcmpTimeExceed  = 8'd11;
  localparam logic [7:0] IcmpParamProb   = 8'd12;
  localparam logic [7:0] IcmpTstamp      = 8'd13;
  localparam logic [7:0] IcmpTstampReply = 8'd14;
  localparam logic [7:0] IcmpInfo        = 8'd15;
  localparam logic [7:0] IcmpInfoReply   = 8'd16;
  localparam logic [7:0] IcmpMask        = 8'd17;
  localparam logic [7:0] IcmpMaskReply   = 8'd18;
  localparam logic [7:0] IcmpDns         = 8'd37;
  localparam logic [7:0] IcmpDnsReply    = 8'd38;

endpackage

module ehv_checker import ehv_pkg::*; import ehv_tb_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MaxFrameBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned verdicts_checked,
  output logic [11:0] outcomes_seen
);

  // header fields captured from the frame in flight
  logic [11:0] byte_cnt;
  logic [15:0] etype;
  logic        arp_fmt_ok;
  logic [3:0]  ihl_words;
  logic [15:0] ip_len;
  logic [15:0] frag;
  logic [7:0]  proto;
  logic [3:0]  tcp_words;
  logic [15:0] udp_len;
  logic [7:0]  icmp_type;
  logic        saturated;

  out_item_t   verdict_q[$];
  int unsigned errors = 0;
  int unsigned checked = 0;
  logic [11:0] seen = '0;

  initial begin
    fail_count = 0;
    pending = 0;
    verdicts_checked = 0;
    outcomes_seen = '0;
  end

  task automatic clear_frame();
    byte_cnt   = '0;
    etype      = '0;
    arp_fmt_ok = 1'b1;
    ihl_words  = '0;
    ip_len     = '0;
    frag       = '0;
    proto      = '0;
    tcp_words  = '0;
    udp_len    = '0;
    icmp_type  = '0;
    saturated  = 1'b0;
  endtask

  // 0 marks a type with no known message size
  function automatic int unsigned icmp_msg_bytes(logic [7:0] t);
    case (t)
      IcmpEchoReply, IcmpEcho, IcmpUnreach, IcmpSrcQuench, IcmpRedirect,
      IcmpTimeExceed, IcmpParamProb, IcmpRtrAdvert, IcmpRtrSolicit,
      IcmpInfo, IcmpInfoReply, IcmpDns: return 4;
      IcmpMask, IcmpMaskReply, IcmpDnsReply: return 8;
      IcmpTstamp, IcmpTstampReply: return 16;
      default: return 0;
    endcase
  endfunction

  function automatic out_item_t judge();
    out_item_t   v;
    int unsigned len, hl, tp, th, fin, sz;
    len = byte_cnt;
    fin = len;
    th = 0;
    v.outcome          = OC_OK;
    v.transport_kind   = KIND_NONE;
    v.transport_offset = '0;
    v.payload_offset   = '0;
    v.payload_valid    = 1'b0;
    v.length_saturated = saturated;
    if (len < EthLen) begin
      v.outcome = OC_SHORT_ETH;
    end else if (etype == EtypeArp) begin
      if (len < EthLen + 8) begin
        v.outcome = OC_ARP_SHORT;
      end else if (!arp_fmt_ok) begin
        v.outcome = OC_ARP_FMT;
      end else begin
        v.outcome = OC_ARP_OK;
        v.payload_offset = EthLen + 12'd8;
        v.payload_valid = (len >= ArpEnd);
        if (len > ArpEnd) fin = ArpEnd;
      end
    end else if (etype != EtypeIp) begin
      v.outcome = OC_UNKNOWN;
    end else if (len < EthLen + 20) begin
      v.outcome = OC_IP_SHORT;
    end else begin
      hl = 4 * ihl_words;
      if (EthLen + hl > len) begin
        v.outcome = OC_IHL_OVER;
      end else if (EthLen + ip_len > len) begin
        v.outcome = OC_LEN_OVER;
      end else if (frag[13:0] != 14'd0) begin
        v.outcome = OC_FRAGMENT;
      end else begin
        fin = EthLen + ip_len;
        tp = EthLen + hl;
        case (proto)
          ProtoIcmp: begin
            v.transport_kind = KIND_ICMP;
            th = 4;
          end
          ProtoTcp: begin
            v.transport_kind = KIND_TCP;
            // fixed tcp header must fit before the data offset is trusted
            if (tp + 20 > fin) v.outcome = OC_L4_SHORT;
            else th = 4 * tcp_words;
          end
          ProtoUdp: begin
            v.transport_kind = KIND_UDP;
            th = 8;
          end
          default: v.outcome = OC_PROTO;
        endcase
        if (v.outcome == OC_OK && tp + th > fin) v.outcome = OC_L4_SHORT;
        if (v.outcome == OC_OK) begin
          v.transport_offset = tp;
          v.payload_offset = tp + th;
          case (v.transport_kind)
            KIND_ICMP: begin
              sz = icmp_msg_bytes(icmp_type);
              v.payload_valid = (sz != 0) && (tp + th + sz <= fin);
            end
            KIND_TCP: v.payload_valid = (tp + th < fin);
            default:  v.payload_valid = (tp + udp_len <= fin);
          endcase
        end
      end
    end
    v.end_offset = fin[11:0];
    return v;
  endfunction

  task automatic take_byte(in_item_t item);
    int unsigned pos, tp;
    logic [7:0]  b;
    b = item.frame_byte;
    if (byte_cnt < MAX_FRAME_BYTES) begin
      pos = byte_cnt;
      // fixed offsets: ethertype, then ip header or arp format words
      case (pos)
        12: etype[15:8] = b;
        13: etype[7:0] = b;
        14: begin
          ihl_words = b[3:0];
          if (b != ArpHwEther[15:8]) arp_fmt_ok = 1'b0;
        end
        15: if (b != ArpHwEther[7:0]) arp_fmt_ok = 1'b0;
        16: begin
          ip_len[15:8] = b;
          if (b != EtypeIp[15:8]) arp_fmt_ok = 1'b0;
        end
        17: begin
          ip_len[7:0] = b;
          if (b != EtypeIp[7:0]) arp_fmt_ok = 1'b0;
        end
        18: if (b != ArpHwLen) arp_fmt_ok = 1'b0;
        19: if (b != ArpProtoLen) arp_fmt_ok = 1'b0;
        20: frag[15:8] = b;
        21: frag[7:0] = b;
        23: proto = b;
        default: ;
      endcase
      // transport fields follow the ihl seen so far
      tp = EthLen + 4 * ihl_words;
      if (pos == tp) icmp_type = b;
      if (pos == tp + 4) udp_len[15:8] = b;
      if (pos == tp + 5) udp_len[7:0] = b;
      if (pos == tp + 12) tcp_words = b[7:4];
      byte_cnt = byte_cnt + 12'd1;
    end else begin
      saturated = 1'b1;
    end
    if (item.last_byte) begin
      verdict_q.push_back(judge());
      clear_frame();
    end
  endtask

  task automatic report_bad(string msg);
    $display("[ehv_checker] %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic compare_field(string name, logic [15:0] got_v, logic [15:0] want_v);
    if (got_v !== want_v)
      report_bad($sformatf("verdict %0d %s: got %0d, want %0d",
                           checked, name, got_v, want_v));
  endtask

  task automatic check_verdict(out_item_t got);
    out_item_t want;
    if (verdict_q.size() == 0) begin
      report_bad($sformatf("verdict %0d arrived with no frame waiting", checked));
      return;
    end
    want = verdict_q.pop_front();
    compare_field("outcome", got.outcome, want.outcome);
    compare_field("end_offset", got.end_offset, want.end_offset);
    compare_field("transport_kind", got.transport_kind, want.transport_kind);
    compare_field("transport_offset", got.transport_offset, want.transport_offset);
    compare_field("payload_offset", got.payload_offset, want.payload_offset);
    compare_field("payload_valid", got.payload_valid, want.payload_valid);
    compare_field("length_saturated", got.length_saturated, want.length_saturated);
    seen[want.outcome] = 1'b1;
    checked++;
  endtask

  // a verdict leaves only after its frame's last byte was taken, so check before taking
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      verdict_q.delete();
    end else begin
      if (out_valid && !out_stall) check_verdict(out_data);
      if (in_valid && !in_stall) take_byte(in_data);
    end
    pending          <= verdict_q.size();
    fail_count       <= errors;
    verdicts_checked <= checked;
    outcomes_seen    <= seen;
  end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  import ehv_pkg::*;
  import ehv_tb_pkg::*;

  // block interface, every input known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  // status handed up from the checker
  int unsigned fail_count;
  int unsigned pending;
  int unsigned verdicts_checked;
  logic [11:0] outcomes_seen;

  // frame under construction, one entry per byte
  logic [7:0]  frame[$];

  // idle behavior: 0 never waits, 1 waits now and then, 2 waits 0..9 every item
  int          send_mode = 1;
  int          stall_mode = 1;

  int unsigned frames_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned long_sent = 0;
  int          long_left = 2;

  ethernet_ip_header_validator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ehv_checker #(.MAX_FRAME_BYTES(MaxFrameBytesDefault)) u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .verdicts_checked (verdicts_checked),
    .outcomes_seen    (outcomes_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("ethernet_ip_header_validator_unit: mismatch");
    $finish;
  end

  function automatic int draw_wait(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
      default: return $urandom_range(0, 9);
    endcase
  endfunction

  // result side: each verdict draws its own stall before being taken
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = draw_wait(stall_mode);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // random filler of the given length
  task automatic make_frame(int len);
    frame.delete();
    repeat (len) frame.push_back($urandom_range(0, 255));
  endtask

  // overwrite a byte only if the frame reaches that far
  task automatic put(int pos, logic [7:0] v);
    if (pos < frame.size()) frame[pos] = v;
  endtask

  task automatic make_arp(int len, bit corrupt);
    int idx;
    make_frame(len);
    put(12, EtypeArp[15:8]);
    put(13, EtypeArp[7:0]);
    put(14, ArpHwEther[15:8]);
    put(15, ArpHwEther[7:0]);
    put(16, EtypeIp[15:8]);
    put(17, EtypeIp[7:0]);
    put(18, ArpHwLen);
    put(19, ArpProtoLen);
    // flip one bit in one of the six format bytes
    if (corrupt) begin
      idx = 14 + $urandom_range(0, 5);
      if (idx < frame.size()) frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
  endtask

  // ipv4 frame; with a small ihl the transport fields land on header bytes
  task automatic make_ip(logic [3:0] ihl, logic [15:0] tot, int len, logic [15:0] frag,
                         logic [7:0] proto, logic [7:0] l4_first, logic [15:0] udp_len,
                         logic [3:0] tcp_words);
    int tp;
    make_frame(len);
    put(12, EtypeIp[15:8]);
    put(13, EtypeIp[7:0]);
    put(14, {4'h4, ihl});
    put(16, tot[15:8]);
    put(17, tot[7:0]);
    put(20, frag[15:8]);
    put(21, frag[7:0]);
    put(23, proto);
    tp = EthLen + 4 * ihl;
    put(tp, l4_first);
    if (proto == ProtoUdp) begin
      put(tp + 4, udp_len[15:8]);
      put(tp + 5, udp_len[7:0]);
    end
    if (proto == ProtoTcp) put(tp + 12, {tcp_words, 4'h0});
  endtask

  task automatic random_ip();
    int          ihl_v, th, tot, len, pick;
    logic [7:0]  proto_v, first;
    logic [15:0] frag_v, ulen;
    logic [3:0]  tw;
    ihl_v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : 5;
    tw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
    first = $urandom_range(0, 255);
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      proto_v = ProtoIcmp;
      // mostly types around the known set, now and then anything
      first = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
      th = 4 + $urandom_range(0, 20);
    end else if (pick < 6) begin
      proto_v = ProtoTcp;
      th = 4 * tw;
    end else if (pick < 9) begin
      proto_v = ProtoUdp;
      th = 8;
    end else begin
      proto_v = $urandom_range(0, 255);
      th = $urandom_range(0, 20);
    end
    tot = 4 * ihl_v + th + $urandom_range(0, 24);
    if ($urandom_range(0, 5) == 0) tot = $urandom_range(0, 120);
    ulen = tot - 4 * ihl_v;
    case ($urandom_range(0, 5))
      0: ulen = $urandom_range(0, 65535);
      1: ulen = ulen + $urandom_range(1, 8);
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: frag_v = 16'h0000;
      4: frag_v = 16'h4000;
      5: frag_v = 16'h8000;
      default: frag_v = $urandom_range(0, 65535);
    endcase
    // mostly exact, sometimes padded, sometimes cut short
    len = EthLen + tot;
    case ($urandom_range(0, 7))
      0: len += $urandom_range(1, 6);
      1: len -= $urandom_range(1, 12);
      default: ;
    endcase
    if (len < 1) len = 1;
    make_ip(ihl_v, tot, len, frag_v, proto_v, first, ulen, tw);
  endtask

  task automatic random_frame();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      make_frame($urandom_range(1, 70));
    end else if (pick < 12) begin
      make_frame($urandom_range(1, 13));
    end else if (pick < 17) begin
      make_frame($urandom_range(14, 60));
    end else if (pick < 32) begin
      make_arp($urandom_range(14, 64), $urandom_range(0, 4) == 0);
    end else if (pick < 34 && long_left > 0) begin
      // around and past the length cap
      long_left--;
      make_ip(4'd5, $urandom_range(20, 2100), $urandom_range(2040, 2110), 16'h0000,
              ProtoUdp, 8'h00, 16'd8, 4'd0);
    end else begin
      random_ip();
    end
  endtask

  // one byte per handshake, last_byte on the final one
  task automatic send_frame();
    int i, gap;
    for (i = 0; i < frame.size(); i++) begin
      gap = draw_wait(send_mode);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_data.frame_byte <= frame[i];
      in_data.last_byte <= (i == frame.size() - 1);
      in_valid <= 1'b1;
      do @(posedge clk); while (in_stall);
      bytes_sent++;
    end
    frames_sent++;
    if (frame.size() > MaxFrameBytesDefault) long_sent++;
  endtask

  // hold the sender until every verdict has come back
  task automatic drain();
    int n;
    in_valid <= 1'b0;
    n = 0;
    @(posedge clk);
    while (pending != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames: every verdict code and the odd corners
    make_frame(1);                           send_frame();
    make_frame(13);                          send_frame();
    make_ip(4'd5, 16'd20, 14, 16'h0000, ProtoUdp, 8'h00, 16'd8, 4'd0);
    send_frame();
    make_frame(40);
    put(12, EtypeIpv6[15:8]);
    put(13, EtypeIpv6[7:0]);
    send_frame();
    make_arp(21, 1'b0);                      send_frame();
    make_arp(42, 1'b1);                      send_frame();
    make_arp(42, 1'b0);                      send_frame();
    // arp padded out, verdict trims the end
    make_arp(60, 1'b0);                      send_frame();
    // arp body incomplete, no payload
    make_arp(30, 1'b0);                      send_frame();
    make_ip(4'd15, 16'd60, 40, 16'h0000, ProtoUdp, 8'h00, 16'd8, 4'd0);
    send_frame();
    make_ip(4'd5, 16'd100, 40, 16'h0000, ProtoTcp, 8'h00, 16'd0, 4'd5);
    send_frame();
    // more-fragments bit, then a nonzero offset
    make_ip(4'd5, 16'd28, 42, 16'h2000, ProtoUdp, 8'h00, 16'd8, 4'd0);
    send_frame();
    make_ip(4'd5, 16'd28, 42, 16'h0001, ProtoUdp, 8'h00, 16'd8, 4'd0);
    send_frame();
    // reserved and don't-fragment bits do not count as fragmentation
    make_ip(4'd5, 16'd28, 42, 16'hC000, ProtoUdp, 8'h00, 16'd8, 4'd0);
    send_frame();
    make_ip(4'd5, 16'd40, 54, 16'h0000, ProtoIgmp, 8'h00, 16'd0, 4'd0);
    send_frame();
    // tcp header cut short by total length
    make_ip(4'd5, 16'd30, 44, 16'h0000, ProtoTcp, 8'h00, 16'd0, 4'd5);
    send_frame();
    make_ip(4'd5, 16'd60, 74, 16'h0000, ProtoTcp, 8'h00, 16'd0, 4'd5);
    send_frame();
    // tcp with no data, padding past the ip end
    make_ip(4'd5, 16'd40, 60, 16'h0000, ProtoTcp, 8'h00, 16'd0, 4'd5);
    send_frame();
    // tcp data offset below the minimum, taken as given
    make_ip(4'd5, 16'd40, 54, 16'h0000, ProtoTcp, 8'h00, 16'd0, 4'd0);
    send_frame();
    // udp length runs past the end
    make_ip(4'd5, 16'd28, 42, 16'h0000, ProtoUdp, 8'h00, 16'd200, 4'd0);
    send_frame();
    make_ip(4'd5, 16'd28, 42, 16'h0000, ProtoIcmp, IcmpEcho, 16'd0, 4'd0);
    send_frame();
    make_ip(4'd5, 16'd28, 42, 16'h0000, ProtoIcmp, IcmpTstamp, 16'd0, 4'd0);
    send_frame();
    // icmp type with no known size
    make_ip(4'd5, 16'd60, 74, 16'h0000, ProtoIcmp, $urandom_range(44, 255), 16'd0, 4'd0);
    send_frame();
    // total length shorter than the ip header
    make_ip(4'd5, 16'd10, 40, 16'h0000, ProtoUdp, 8'h00, 16'd8, 4'd0);
    send_frame();
    // zero ihl puts transport at the ip header
    make_ip(4'd0, 16'd40, 54, 16'h0000, ProtoUdp, 8'h00, 16'd8, 4'd0);
    send_frame();
    // all-ones and all-zeros bytes
    make_frame(30);
    foreach (frame[k]) frame[k] = 8'hFF;
    send_frame();
    make_frame(30);
    foreach (frame[k]) frame[k] = 8'h00;
    send_frame();
    // runs past the byte cap
    make_ip(4'd5, 16'd1500, 2060, 16'h0000, ProtoTcp, 8'h00, 16'd0, 4'd5);
    send_frame();

    drain();

    // random traffic, idle modes shift every few frames
    while (bytes_sent < 1500 || frames_sent < 100) begin
      if ($urandom_range(0, 5) == 0) send_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 5) == 0) stall_mode = $urandom_range(0, 2);
      random_frame();
      send_frame();
      if ($urandom_range(0, 24) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk);

    $display("run: %0d frames, %0d bytes (%0d past the byte cap), %0d verdicts checked",
             frames_sent, bytes_sent, long_sent, verdicts_checked);
    $display("verdict codes seen, one bit per code with code 0 rightmost: %b",
             outcomes_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ethernet_ip_header_validator_unit: match");
    end else begin
      $display("ethernet_ip_header_validator_unit: mismatch");
    end
    $finish;
  end

endmodule
